// ===== rtl/cylinder_zone_point_trigger_unit_defines.svh =====
// assertion helpers shared by the zone trigger modules
// each macro expects clk and rst_n in the scope where it is used
`ifndef CYLINDER_ZONE_POINT_TRIGGER_UNIT_DEFINES_SVH
`define CYLINDER_ZONE_POINT_TRIGGER_UNIT_DEFINES_SVH

// same-cycle implication
`define CZPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CZPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/czpt_pkg.sv =====
`timescale 1ns / 1ps

package czpt_pkg;

  // point coordinates are taken from the low COORD_BITS bits of each field
  localparam int unsigned COORD_BITS       = 16;
  localparam int unsigned MAX_CLOUD_POINTS = 524288;

  // counters
  localparam int unsigned CNT_W = 20;
  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_CLOUD_POINTS < (2 ** CNT_W) - 1) ? CNT_W'(MAX_CLOUD_POINTS) : {CNT_W{1'b1}};

  // queue between classifier and trigger logic
  localparam int unsigned QUEUE_DEPTH  = 8;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned CREDIT_W     = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  // datapath widths
  localparam int unsigned IN_W      = 16;
  localparam int unsigned PT_W      = 17;
  localparam int unsigned SIGN_IDX  = (COORD_BITS <= IN_W) ? COORD_BITS - 1 : IN_W;
  localparam int unsigned D_W       = 18;
  localparam int unsigned PROD_W    = 34;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned T_W       = SUM_W - 14;
  localparam int unsigned TSQ_W     = 2 * T_W - 1;
  localparam int unsigned SCALED_W  = TSQ_W + 2;
  localparam int unsigned PERP4_W   = SUM_W + 2;
  localparam int unsigned THR_W     = 34;

  // configuration port
  localparam int unsigned REG_W      = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [REG_W-1:0] REG_MIDPOINT = 3'd0;
  localparam logic [REG_W-1:0] REG_AXIS     = 3'd1;
  localparam logic [REG_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [REG_W-1:0] REG_LENGTH   = 3'd3;
  localparam logic [REG_W-1:0] REG_BORDER   = 3'd4;
  localparam logic [REG_W-1:0] REG_TRIGGER  = 3'd5;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_BORDER  = 2'd1,
    CLS_INSIDE  = 2'd2
  } czpt_class_t;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic signed [IN_W-1:0] point_z;
    logic                   cloud_end;
  } czpt_in_t;

  typedef struct packed {
    logic [1:0]       point_class;
    logic             zone_active;
    logic             started;
    logic             ended;
    logic [CNT_W-1:0] inside_total;
    logic [CNT_W-1:0] near_total;
    logic             cloud_done;
  } czpt_out_t;

  // zone geometry and squared thresholds (bounds scaled by 2)
  typedef struct packed {
    logic signed [15:0] mid_x;
    logic signed [15:0] mid_y;
    logic signed [15:0] mid_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [THR_W-1:0]   ax_outer;
    logic [THR_W-1:0]   ax_inner;
    logic [THR_W-1:0]   rad_outer;
    logic [THR_W-1:0]   rad_inner;
  } czpt_zone_t;

  // one classified point on its way to the trigger logic
  typedef struct packed {
    czpt_class_t cls;
    logic        last;
  } czpt_item_t;

  // sign extension from COORD_BITS, upper field bits dropped
  function automatic logic signed [PT_W-1:0] ext_coord(input logic [IN_W-1:0] raw);
    logic [PT_W-1:0] vz;
    logic [PT_W-1:0] r;
    vz = {1'b0, raw};
    for (int i = 0; i < PT_W; i++) begin
      r[i] = (i < COORD_BITS) ? vz[i] : vz[SIGN_IDX];
    end
    return signed'(r);
  endfunction

endpackage

// ===== rtl/czpt_cfg.sv =====
`timescale 1ns / 1ps

module czpt_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [czpt_pkg::REG_W-1:0]       cfg_index,
  input  logic [czpt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output czpt_pkg::czpt_zone_t             zone,
  output logic [czpt_pkg::CNT_W-1:0]       trig_count
);
  import czpt_pkg::*;

  logic [CFG_DATA_W-1:0] mid_r;
  logic [CFG_DATA_W-1:0] axis_r;
  logic [15:0]           radius_r;
  logic [15:0]           length_r;
  logic [15:0]           border_r;
  logic [CNT_W-1:0]      trig_r;

  logic signed [17:0] l_in;
  logic signed [17:0] r_in;
  logic [16:0]        l_mag;
  logic [16:0]        r_mag;
  logic [31:0]        l_sq;
  logic [31:0]        r_sq;
  logic [THR_W-1:0]   li_sq;
  logic [THR_W-1:0]   ri_sq;
  czpt_zone_t         zone_r;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r    <= '0;
      axis_r   <= CFG_DATA_W'(16384);
      radius_r <= 16'd10;
      length_r <= 16'd50;
      border_r <= 16'd2;
      trig_r   <= CNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIDPOINT: mid_r    <= cfg_data;
        REG_AXIS:     axis_r   <= cfg_data;
        REG_RADIUS:   radius_r <= cfg_data[15:0];
        REG_LENGTH:   length_r <= cfg_data[15:0];
        REG_BORDER:   border_r <= cfg_data[15:0];
        REG_TRIGGER:  trig_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // inner bounds: bound minus twice the border, used by magnitude
  always_comb begin
    l_in  = $signed({2'b00, length_r}) - $signed({1'b0, border_r, 1'b0});
    r_in  = $signed({2'b00, radius_r}) - $signed({1'b0, border_r, 1'b0});
    l_mag = l_in[17] ? 17'(-l_in) : l_in[16:0];
    r_mag = r_in[17] ? 17'(-r_in) : r_in[16:0];
    l_sq  = 32'(length_r) * 32'(length_r);
    r_sq  = 32'(radius_r) * 32'(radius_r);
    li_sq = THR_W'(l_mag) * THR_W'(l_mag);
    ri_sq = THR_W'(r_mag) * THR_W'(r_mag);
  end

  // zone geometry and derived thresholds, refreshed every cycle
  always_ff @(posedge clk) begin
    zone_r.mid_x     <= mid_r[15:0];
    zone_r.mid_y     <= mid_r[31:16];
    zone_r.mid_z     <= mid_r[47:32];
    zone_r.axis_x    <= axis_r[15:0];
    zone_r.axis_y    <= axis_r[31:16];
    zone_r.axis_z    <= axis_r[47:32];
    zone_r.ax_outer  <= THR_W'(l_sq);
    zone_r.ax_inner  <= li_sq;
    zone_r.rad_outer <= THR_W'(r_sq);
    zone_r.rad_inner <= ri_sq;
  end

  assign zone       = zone_r;
  assign trig_count = trig_r;

endmodule

// ===== rtl/czpt_front.sv =====
`timescale 1ns / 1ps

module czpt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  czpt_pkg::czpt_in_t            in_data,
  input  czpt_pkg::czpt_zone_t          zone,
  input  logic [czpt_pkg::QCNT_W-1:0]   q_count,
  output logic                          push,
  output czpt_pkg::czpt_item_t          push_item
);
  import czpt_pkg::*;

  logic [FRONT_STAGES-1:0] vld_r;
  logic [FRONT_STAGES-1:0] last_r;
  logic [CREDIT_W-1:0]     credit;
  logic                    accept;

  logic signed [PT_W-1:0]   pt    [3];
  logic signed [15:0]       mid   [3];
  logic signed [15:0]       axis  [3];
  logic signed [D_W-1:0]    d_r   [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic [PROD_W-1:0]        sq_r  [3];
  logic signed [SUM_W-1:0]  sq_full [3];
  logic signed [SUM_W-1:0]  dot_r;
  logic [SUM_W-1:0]         dd_r;
  logic signed [T_W-1:0]    t;
  logic signed [2*T_W-1:0]  t_full;
  logic [TSQ_W-1:0]         tt_r;
  logic [SUM_W-1:0]         dd4_r;
  logic [SCALED_W-1:0]      tt4;
  czpt_class_t              ax_cls;
  czpt_class_t              ax_r;
  logic [SUM_W-1:0]         perp_r;
  logic [PERP4_W-1:0]       p4;
  czpt_class_t              rad_cls;
  czpt_class_t              cls_r;

  // admit a point only when the queue has room for everything in flight
  always_comb begin
    credit   = CREDIT_W'(q_count) + CREDIT_W'($countones(vld_r));
    in_ready = credit < CREDIT_W'(QUEUE_DEPTH);
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[FRONT_STAGES-2:0], in_data.cloud_end};
  end

  // stage 1: offset from the zone centre
  always_comb begin
    pt[0]   = ext_coord(in_data.point_x);
    pt[1]   = ext_coord(in_data.point_y);
    pt[2]   = ext_coord(in_data.point_z);
    mid[0]  = zone.mid_x;
    mid[1]  = zone.mid_y;
    mid[2]  = zone.mid_z;
    axis[0] = zone.axis_x;
    axis[1] = zone.axis_y;
    axis[2] = zone.axis_z;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_r[i] <= D_W'(pt[i]) - D_W'(mid[i]);
    end
  end

  // stage 2: per-axis products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = SUM_W'(d_r[i]) * SUM_W'(d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= PROD_W'(d_r[i]) * PROD_W'(axis[i]);
      sq_r[i]   <= sq_full[i][PROD_W-1:0];
    end
  end

  // stage 3: dot product and squared length
  always_ff @(posedge clk) begin
    dot_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    dd_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  // stage 4: axial distance squared, t is floor of dot / 2^14
  always_comb begin
    t      = T_W'(dot_r >>> 14);
    t_full = (2*T_W)'(t) * (2*T_W)'(t);
  end

  always_ff @(posedge clk) begin
    tt_r  <= t_full[TSQ_W-1:0];
    dd4_r <= dd_r;
  end

  // stage 5: axial class and clamped perpendicular distance squared
  always_comb begin
    tt4 = {tt_r, 2'b00};
    if (tt4 > SCALED_W'(zone.ax_outer)) begin
      ax_cls = CLS_OUTSIDE;
    end else if (tt4 > SCALED_W'(zone.ax_inner)) begin
      ax_cls = CLS_BORDER;
    end else begin
      ax_cls = CLS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    ax_r   <= ax_cls;
    perp_r <= (dd4_r >= SUM_W'(tt_r)) ? dd4_r - SUM_W'(tt_r) : '0;
  end

  // stage 6: radial class, the worse class wins
  always_comb begin
    p4 = {perp_r, 2'b00};
    if (p4 > PERP4_W'(zone.rad_outer)) begin
      rad_cls = CLS_OUTSIDE;
    end else if (p4 > PERP4_W'(zone.rad_inner)) begin
      rad_cls = CLS_BORDER;
    end else begin
      rad_cls = CLS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= (ax_r < rad_cls) ? ax_r : rad_cls;
  end

  assign push           = vld_r[FRONT_STAGES-1];
  assign push_item.cls  = cls_r;
  assign push_item.last = last_r[FRONT_STAGES-1];

endmodule

// ===== rtl/czpt_queue.sv =====
`timescale 1ns / 1ps
`include "cylinder_zone_point_trigger_unit_defines.svh"

module czpt_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  czpt_pkg::czpt_item_t         push_item,
  input  logic                         pop,
  output czpt_pkg::czpt_item_t         head,
  output logic                         empty,
  output logic [czpt_pkg::QCNT_W-1:0]  count
);
  import czpt_pkg::*;

  czpt_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  `CZPT_ASSERT_IMPL(a_no_overflow, push, cnt_r < QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `CZPT_ASSERT_IMPL(a_no_underflow, pop, cnt_r != '0, "pop from empty queue")
  `CZPT_ASSERT_NEXT(a_fill_up, push && !pop, cnt_r == QCNT_W'($past(cnt_r) + 1'b1), "fill level lost a word")

endmodule

// ===== rtl/czpt_back.sv =====
`timescale 1ns / 1ps
`include "cylinder_zone_point_trigger_unit_defines.svh"

module czpt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  czpt_pkg::czpt_item_t        head,
  output logic                        pop,
  input  logic [czpt_pkg::CNT_W-1:0]  trig_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output czpt_pkg::czpt_out_t         out_data
);
  import czpt_pkg::*;

  logic             active_r;
  logic             active_nxt;
  logic             decided_r;
  logic             decided_nxt;
  logic [CNT_W-1:0] inside_r;
  logic [CNT_W-1:0] inside_nxt;
  logic [CNT_W-1:0] near_r;
  logic [CNT_W-1:0] near_nxt;
  logic [CNT_W-1:0] ins_upd;
  logic [CNT_W-1:0] near_upd;
  logic             dec_upd;
  logic             started;
  logic             ended;
  logic             out_valid_r;
  logic             out_valid_nxt;
  czpt_out_t        out_data_r;
  czpt_out_t        out_data_nxt;

  // take a word when the output register is free or being emptied
  assign pop = !q_empty && (!out_valid_r || out_ready);

  // per-cloud counting and trigger decision
  always_comb begin
    ins_upd     = inside_r;
    near_upd    = near_r;
    dec_upd     = decided_r;
    active_nxt  = active_r;
    started     = 1'b0;
    ended       = 1'b0;
    if (!decided_r) begin
      if (head.cls == CLS_INSIDE && inside_r < CNT_CAP) begin
        ins_upd = inside_r + 1'b1;
      end
      if (head.cls != CLS_OUTSIDE && near_r < CNT_CAP) begin
        near_upd = near_r + 1'b1;
      end
      if (active_r && near_upd >= trig_count) begin
        dec_upd = 1'b1;
      end else if (!active_r && ins_upd >= trig_count) begin
        active_nxt = 1'b1;
        started    = 1'b1;
        dec_upd    = 1'b1;
      end
      if (head.last && !dec_upd && active_r) begin
        active_nxt = 1'b0;
        ended      = 1'b1;
      end
    end
    inside_nxt  = head.last ? '0 : ins_upd;
    near_nxt    = head.last ? '0 : near_upd;
    decided_nxt = head.last ? 1'b0 : dec_upd;

    out_data_nxt.point_class  = head.cls;
    out_data_nxt.zone_active  = active_nxt;
    out_data_nxt.started      = started;
    out_data_nxt.ended        = ended;
    out_data_nxt.inside_total = ins_upd;
    out_data_nxt.near_total   = near_upd;
    out_data_nxt.cloud_done   = head.last;

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      decided_r   <= 1'b0;
      inside_r    <= '0;
      near_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        active_r  <= active_nxt;
        decided_r <= decided_nxt;
        inside_r  <= inside_nxt;
        near_r    <= near_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CZPT_ASSERT_NEXT(a_cloud_clear, pop && head.last, (inside_r == '0) && (near_r == '0) && !decided_r, "counters not cleared at cloud end")
  `CZPT_ASSERT_NEXT(a_start_latch, pop && started && !head.last, active_r && decided_r, "start did not latch")
  `CZPT_ASSERT_NEXT(a_frozen, pop && decided_r && !head.last, (inside_r == $past(inside_r)) && (near_r == $past(near_r)), "counters moved after decision")
  `CZPT_ASSERT_IMPL(a_end_flags, out_valid_r && out_data_r.ended, out_data_r.cloud_done && !out_data_r.zone_active && !out_data_r.started, "end flagged off a cloud end")

endmodule

// ===== rtl/cylinder_zone_point_trigger_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake               word
// in_       input      in_valid / in_ready     czpt_in_t: x, y, z, cloud_end
// out_      output     out_valid / out_ready   czpt_out_t: class, trigger state, totals
// cfg_      input      cfg_valid / cfg_ready   register index and 48-bit data
//
// one point per cycle sustained while out_ready stays high; a result word passes through
// six classifier stages (the first loading at the accepting edge), one queue slot, output reg
// the six-stage classifier runs ahead into an 8-word queue; in_ready drops once queue
// words plus points in flight reach the queue depth, so output stalls back up there
// the trigger counters update once per point, as its word is popped, in the back end
// reset is synchronous, active low; thresholds are registered from the written fields; cfg_ready stays high

module cylinder_zone_point_trigger_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  czpt_pkg::czpt_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output czpt_pkg::czpt_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [czpt_pkg::REG_W-1:0]       cfg_index,
  input  logic [czpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import czpt_pkg::*;

  czpt_zone_t        zone;
  logic [CNT_W-1:0]  trig_count;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  czpt_item_t        push_item;
  logic              pop;
  czpt_item_t        head;
  logic              q_empty;

  // configuration registers and thresholds
  czpt_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .zone       (zone),
    .trig_count (trig_count)
  );

  // point classifier
  czpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .zone      (zone),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  czpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  // trigger logic and output register
  czpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .trig_count (trig_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
